// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) else $error(msg);

// cons must hold in the same cycle as ante
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/rsi_pkg.sv -----
// Types, constants and helpers of the ray/sphere intersection unit.
package rsi_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned NORM_W   = 18;
    localparam int unsigned WIDE_W   = 66;
    localparam int unsigned PROD_W   = 64;
    localparam int unsigned VN_W     = 31;
    localparam int unsigned IN_W     = 256;
    localparam int unsigned OUT_W    = 184;
    localparam int unsigned SQRT_LAT = 32;
    localparam int unsigned DIV_LAT  = 33;

    localparam logic [30:0] RADIUS_RESET = 31'd65536;

    typedef enum logic [1:0] {
        REG_CENTER_X = 2'd0,
        REG_CENTER_Y = 2'd1,
        REG_CENTER_Z = 2'd2,
        REG_RADIUS   = 2'd3
    } cfg_reg_t;

    typedef logic signed [WORD_W-1:0] word_t;

    // last member sits in the low bits: origin x..z, dir x..z, t_min, t_max
    typedef struct packed {
        word_t       t_max;
        word_t       t_min;
        word_t [2:0] dir;
        word_t [2:0] org;
    } ray_t;

    typedef struct packed {
        ray_t  ray;
        word_t a;
        word_t b;
        word_t c;
        logic  live;
    } sq_side_t;

    typedef struct packed {
        ray_t  ray;
        word_t q;
        logic  live;
    } dv_side_t;

    typedef struct packed {
        word_t                t;
        word_t [2:0]          p;
        logic [2:0][VN_W-1:0] vn;
        logic                 live;
    } nq_side_t;

    typedef struct packed {
        word_t       t;
        word_t [2:0] p;
        logic        len_zero;
        logic        live;
    } nd_side_t;

    localparam logic signed [WIDE_W-1:0] SAT_HI = WIDE_W'(64'sh7fff_ffff);
    localparam logic signed [WIDE_W-1:0] SAT_LO = WIDE_W'(-64'sh8000_0000);
    localparam logic signed [32:0]       NRM_HI = 33'sh0_4000_0000;
    localparam logic signed [32:0]       NRM_LO = -33'sh0_4000_0000;

    function automatic word_t sat_word(input logic signed [WIDE_W-1:0] x);
        word_t r;
        if (x > SAT_HI) begin
            r = 32'sh7fff_ffff;
        end else if (x < SAT_LO) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[WORD_W-1:0];
        end
        return r;
    endfunction

    // |x| < 2^30
    function automatic logic in_norm_range(input logic signed [32:0] x);
        return (x > NRM_LO) && (x < NRM_HI);
    endfunction

endpackage

// ----- sv/rsi_delay.sv -----
// Delay line with a valid bit per stage, advanced by the pipeline enable.
module rsi_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             vld_in,
    input  logic [WIDTH-1:0] data_in,
    output logic             vld_out,
    output logic [WIDTH-1:0] data_out
);
    logic [DEPTH-1:0] vld_reg;
    logic [WIDTH-1:0] data_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DEPTH-2:0], vld_in};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg[0] <= data_in;
            for (int i = 1; i < DEPTH; i++) begin
                data_reg[i] <= data_reg[i-1];
            end
        end
    end

    assign vld_out  = vld_reg[DEPTH-1];
    assign data_out = data_reg[DEPTH-1];
endmodule

// ----- sv/rsi_isqrt.sv -----
// Pipelined integer square root, one result bit per stage.
module rsi_isqrt (
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] rad,
    output logic [31:0] root
);
    import rsi_pkg::*;

    localparam int STEPS = SQRT_LAT;

    logic [63:0] x_reg    [STEPS-1];
    logic [33:0] rem_reg  [STEPS-1];
    logic [31:0] root_reg [STEPS];
    logic [63:0] x_in     [STEPS];
    logic [33:0] rem_in   [STEPS];
    logic [31:0] root_in  [STEPS];

    assign x_in[0]    = rad;
    assign rem_in[0]  = '0;
    assign root_in[0] = '0;

    for (genvar s = 1; s < STEPS; s++) begin : g_link
        assign x_in[s]    = x_reg[s-1];
        assign rem_in[s]  = rem_reg[s-1];
        assign root_in[s] = root_reg[s-1];
    end

    for (genvar s = 0; s < STEPS; s++) begin : g_step
        logic [35:0] rem_sh;
        logic [35:0] trial;
        logic        take;

        // bring down the next two radicand bits, try root*4+1
        assign rem_sh = {rem_in[s], x_in[s][63:62]};
        assign trial  = {2'b00, root_in[s], 2'b01};
        assign take   = (rem_sh >= trial);

        always_ff @(posedge aclk) begin
            if (en) begin
                root_reg[s] <= {root_in[s][30:0], take};
            end
        end

        if (s < STEPS - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    x_reg[s]   <= {x_in[s][61:0], 2'b00};
                    rem_reg[s] <= take ? 34'(rem_sh - trial) : rem_sh[33:0];
                end
            end
        end
    end

    assign root = root_reg[STEPS-1];
endmodule

// ----- sv/rsi_div.sv -----
// Pipelined signed divider, truncating, quotient saturated to 32 bits.
module rsi_div (
    input  logic                aclk,
    input  logic                en,
    input  logic signed [63:0]  num,
    input  logic signed [31:0]  den,
    output logic signed [31:0]  quo
);
    import rsi_pkg::*;

    localparam int QB = DIV_LAT - 2;

    logic [63:0]   rem_reg [QB];
    logic [31:0]   dm_reg  [QB];
    logic [QB-1:0] q_reg   [QB+1];
    logic          neg_reg [QB+1];
    logic          ovf_reg [QB+1];
    logic signed [31:0] quo_reg;

    logic [63:0] num_mag;
    logic [31:0] den_mag;

    assign num_mag = num[63] ? 64'(-num) : 64'(num);
    assign den_mag = den[31] ? 32'(-den) : 32'(den);

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= num_mag;
            dm_reg[0]  <= den_mag;
            q_reg[0]   <= '0;
            neg_reg[0] <= num[63] ^ den[31];
            // quotient would not fit in 31 magnitude bits
            ovf_reg[0] <= (num_mag >= {1'b0, den_mag, 31'b0});
        end
    end

    for (genvar j = 1; j <= QB; j++) begin : g_step
        localparam int K = QB - j;
        logic [63:0]   shifted;
        logic          take;
        logic [QB-1:0] q_next;

        assign shifted = 64'(dm_reg[j-1]) << K;
        assign take    = (rem_reg[j-1] >= shifted);

        always_comb begin
            q_next    = q_reg[j-1];
            q_next[K] = take;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[j]   <= q_next;
                neg_reg[j] <= neg_reg[j-1];
                ovf_reg[j] <= ovf_reg[j-1];
            end
        end

        if (j < QB) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[j] <= take ? rem_reg[j-1] - shifted : rem_reg[j-1];
                    dm_reg[j]  <= dm_reg[j-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (ovf_reg[QB]) begin
                quo_reg <= neg_reg[QB] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            end else if (neg_reg[QB]) begin
                quo_reg <= -$signed({1'b0, q_reg[QB]});
            end else begin
                quo_reg <= $signed({1'b0, q_reg[QB]});
            end
        end
    end

    assign quo = quo_reg;
endmodule

// ----- sv/ray_sphere_intersect_unit.sv -----
// Ray/sphere intersection unit: top level.
// Usage:
//   The sphere center and radius are loaded over the cfg channel (index 0..2
//   center x/y/z, 3 radius); the user must do so while no ray is in flight,
//   which the block does not enforce. Rays enter on the s_ stream, one word
//   per cycle; each word yields exactly one result word on the m_ stream, in
//   order. m_tuser is the hit flag; on a miss all m_tdata fields are zero.
//   Between acceptance and m_tvalid lie five setup stages, a 32-stage square
//   root for the discriminant, the q register, 33-stage dividers for the
//   roots, six stages for the hit point and the normal length, a second
//   32-stage square root, the normal divide setup register and 33-stage
//   dividers for the normal, then the output register.
//   Throughput is one ray per cycle. The whole pipeline moves on one enable;
//   while m_tvalid is high and m_tready low it holds and s_tready is low, so
//   nothing is dropped or repeated.
//   Reset (aresetn low, synchronous) clears every valid bit, sets the center
//   to zero and the radius to 1.0.
module ray_sphere_intersect_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_min, t_max
    input  logic [rsi_pkg::IN_W-1:0]  s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // hit_t, point_x, point_y, point_z, normal_x, normal_y, normal_z, 2 pad bits
    output logic [rsi_pkg::OUT_W-1:0] m_tdata,
    // hit
    output logic [0:0]              m_tuser,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  rsi_pkg::cfg_reg_t       cfg_index,
    input  logic [31:0]             cfg_data
);
    import rsi_pkg::*;

    localparam logic signed [WIDE_W-1:0] DISC_MAX = WIDE_W'(1) <<< (62 - FRAC_BITS);

    // configuration
    word_t       center_x_reg, center_y_reg, center_z_reg;
    logic [30:0] radius_reg;
    word_t       cen [3];

    assign cfg_ready = 1'b1;
    assign cen[0] = center_x_reg;
    assign cen[1] = center_y_reg;
    assign cen[2] = center_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
            radius_reg   <= RADIUS_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_CENTER_X: center_x_reg <= cfg_data;
                REG_CENTER_Y: center_y_reg <= cfg_data;
                REG_CENTER_Z: center_z_reg <= cfg_data;
                REG_RADIUS:   radius_reg   <= cfg_data[30:0];
                default:      radius_reg   <= radius_reg;
            endcase
        end
    end

    logic adv;
    logic m_tvalid_reg;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    // ---------------- stage 1: offset origin ----------------
    ray_t  ray_in;
    word_t org_in [3];
    logic  v1_reg;
    ray_t  ray1_reg;
    word_t o1_reg [3];

    assign ray_in = ray_t'(s_tdata);
    for (genvar i = 0; i < 3; i++) begin : g_in
        assign org_in[i] = ray_in.org[i];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ray1_reg <= ray_in;
            for (int i = 0; i < 3; i++) begin
                o1_reg[i] <= sat_word(WIDE_W'(org_in[i]) - WIDE_W'(cen[i]));
            end
        end
    end

    // ---------------- stage 2: products ----------------
    word_t dir1 [3];
    logic  v2_reg;
    ray_t  ray2_reg;
    logic signed [PROD_W-1:0] dd2_reg [3];
    logic signed [PROD_W-1:0] do2_reg [3];
    logic signed [PROD_W-1:0] oo2_reg [3];
    logic [61:0] rr2_reg;

    for (genvar i = 0; i < 3; i++) begin : g_d1
        assign dir1[i] = ray1_reg.dir[i];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ray2_reg <= ray1_reg;
            for (int i = 0; i < 3; i++) begin
                dd2_reg[i] <= dir1[i] * dir1[i];
                do2_reg[i] <= dir1[i] * o1_reg[i];
                oo2_reg[i] <= o1_reg[i] * o1_reg[i];
            end
            rr2_reg <= radius_reg * radius_reg;
        end
    end

    // ---------------- stage 3: quadratic coefficients ----------------
    logic signed [WIDE_W-1:0] sa, sb, sc;
    logic  v3_reg;
    ray_t  ray3_reg;
    word_t a3_reg, b3_reg, c3_reg;

    always_comb begin
        sa = '0;
        sb = '0;
        sc = '0;
        for (int i = 0; i < 3; i++) begin
            sa = sa + WIDE_W'(dd2_reg[i] >>> FRAC_BITS);
            sb = sb + WIDE_W'(do2_reg[i] >>> FRAC_BITS);
            sc = sc + WIDE_W'(oo2_reg[i] >>> FRAC_BITS);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ray3_reg <= ray2_reg;
            a3_reg   <= sat_word(sa);
            b3_reg   <= sat_word(sb <<< 1);
            c3_reg   <= sat_word(sc - $signed(WIDE_W'(rr2_reg >> FRAC_BITS)));
        end
    end

    // ---------------- stage 4: discriminant products ----------------
    logic  v4_reg;
    ray_t  ray4_reg;
    word_t a4_reg, b4_reg, c4_reg;
    logic signed [PROD_W-1:0] bb4_reg, ac4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (adv) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ray4_reg <= ray3_reg;
            a4_reg   <= a3_reg;
            b4_reg   <= b3_reg;
            c4_reg   <= c3_reg;
            bb4_reg  <= b3_reg * b3_reg;
            ac4_reg  <= a3_reg * c3_reg;
        end
    end

    // ---------------- stage 5: discriminant, radicand ----------------
    logic signed [WIDE_W-1:0] disc, disc_cl;
    logic     v5_reg;
    sq_side_t side5_reg;
    logic [63:0] sqin5_reg;

    assign disc    = WIDE_W'(bb4_reg >>> FRAC_BITS) - (WIDE_W'(ac4_reg >>> FRAC_BITS) <<< 2);
    assign disc_cl = (disc > DISC_MAX) ? DISC_MAX : disc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (adv) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side5_reg.ray  <= ray4_reg;
            side5_reg.a    <= a4_reg;
            side5_reg.b    <= b4_reg;
            side5_reg.c    <= c4_reg;
            // zero-length direction or negative discriminant: miss
            side5_reg.live <= (a4_reg != '0) && !disc[WIDE_W-1];
            sqin5_reg      <= PROD_W'(disc_cl) << FRAC_BITS;
        end
    end

    logic [31:0] sd_root;
    sq_side_t    side6d;
    logic        v6d;

    rsi_isqrt u_sqrt_disc (
        .aclk (aclk),
        .en   (adv),
        .rad  (sqin5_reg),
        .root (sd_root)
    );

    rsi_delay #(.WIDTH($bits(sq_side_t)), .DEPTH(SQRT_LAT)) u_dly_disc (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .vld_in   (v5_reg),
        .data_in  (side5_reg),
        .vld_out  (v6d),
        .data_out (side6d)
    );

    // ---------------- stage 6: q ----------------
    word_t sd, b6, c6;
    logic signed [WIDE_W-1:0] qw;
    logic  v6_reg;
    ray_t  ray6_reg;
    word_t q6_reg, a6_reg, c6_reg;
    logic  live6_reg;

    assign sd = sd_root[31] ? 32'sh7fff_ffff : $signed(sd_root);
    assign b6 = side6d.b;
    assign c6 = side6d.c;
    assign qw = b6[WORD_W-1] ? ((WIDE_W'(sd) - WIDE_W'(b6)) >>> 1)
                             : -((WIDE_W'(b6) + WIDE_W'(sd)) >>> 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (adv) begin
            v6_reg <= v6d;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ray6_reg  <= side6d.ray;
            q6_reg    <= sat_word(qw);
            a6_reg    <= side6d.a;
            c6_reg    <= c6;
            live6_reg <= side6d.live;
        end
    end

    word_t    t0d, t1d;
    dv_side_t side6, side7d;
    logic     v7d;

    assign side6.ray  = ray6_reg;
    assign side6.q    = q6_reg;
    assign side6.live = live6_reg;

    rsi_div u_div_t0 (
        .aclk (aclk),
        .en   (adv),
        .num  (PROD_W'(q6_reg) <<< FRAC_BITS),
        .den  (a6_reg),
        .quo  (t0d)
    );

    rsi_div u_div_t1 (
        .aclk (aclk),
        .en   (adv),
        .num  (PROD_W'(c6_reg) <<< FRAC_BITS),
        .den  (q6_reg),
        .quo  (t1d)
    );

    rsi_delay #(.WIDTH($bits(dv_side_t)), .DEPTH(DIV_LAT)) u_dly_root (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .vld_in   (v6_reg),
        .data_in  (side6),
        .vld_out  (v7d),
        .data_out (side7d)
    );

    // ---------------- stage 7: root ordering and interval test ----------------
    word_t tmin7, tmax7, q7, t1s, lo, hi, tsel;
    logic  in_range;
    logic  v7_reg;
    ray_t  ray7_reg;
    word_t t7_reg;
    logic  live7_reg;

    assign tmin7 = side7d.ray.t_min;
    assign tmax7 = side7d.ray.t_max;
    assign q7    = side7d.q;
    // q of zero: far root is the interval end
    assign t1s   = (q7 == '0) ? tmax7 : t1d;
    assign lo    = (t0d > t1s) ? t1s : t0d;
    assign hi    = (t0d > t1s) ? t0d : t1s;

    always_comb begin
        tsel     = lo;
        in_range = 1'b0;
        priority if (lo >= tmax7 || hi < tmin7) begin
            in_range = 1'b0;
        end else if (lo >= tmin7) begin
            tsel     = lo;
            in_range = 1'b1;
        end else if (hi < tmax7) begin
            tsel     = hi;
            in_range = 1'b1;
        end else begin
            in_range = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v7_reg <= 1'b0;
        end else if (adv) begin
            v7_reg <= v7d;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ray7_reg  <= side7d.ray;
            t7_reg    <= tsel;
            live7_reg <= side7d.live && in_range;
        end
    end

    // ---------------- stage 8: dir * t ----------------
    word_t dir7 [3];
    logic  v8_reg;
    ray_t  ray8_reg;
    word_t t8_reg;
    logic  live8_reg;
    logic signed [PROD_W-1:0] dt8_reg [3];

    for (genvar i = 0; i < 3; i++) begin : g_d7
        assign dir7[i] = ray7_reg.dir[i];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v8_reg <= 1'b0;
        end else if (adv) begin
            v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ray8_reg  <= ray7_reg;
            t8_reg    <= t7_reg;
            live8_reg <= live7_reg;
            for (int i = 0; i < 3; i++) begin
                dt8_reg[i] <= dir7[i] * t7_reg;
            end
        end
    end

    // ---------------- stage 9: hit point ----------------
    word_t org8 [3];
    logic  v9_reg;
    word_t t9_reg;
    logic  live9_reg;
    word_t p9_reg [3];

    for (genvar i = 0; i < 3; i++) begin : g_o8
        assign org8[i] = ray8_reg.org[i];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v9_reg <= 1'b0;
        end else if (adv) begin
            v9_reg <= v8_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            t9_reg    <= t8_reg;
            live9_reg <= live8_reg;
            for (int i = 0; i < 3; i++) begin
                p9_reg[i] <= sat_word(WIDE_W'(org8[i]) + WIDE_W'(dt8_reg[i] >>> FRAC_BITS));
            end
        end
    end

    // ---------------- stage 10: center offset, common downscale ----------------
    logic signed [32:0] vc [3];
    logic [3:0] fits;
    logic [1:0] nsh;
    logic  v10_reg;
    word_t t10_reg;
    logic  live10_reg;
    word_t p10_reg [3];
    logic signed [VN_W-1:0] vn10_reg [3];

    for (genvar i = 0; i < 3; i++) begin : g_vc
        assign vc[i] = 33'(p9_reg[i]) - 33'(cen[i]);
    end

    for (genvar s = 0; s < 4; s++) begin : g_fit
        assign fits[s] = in_norm_range(vc[0] >>> s) && in_norm_range(vc[1] >>> s)
                      && in_norm_range(vc[2] >>> s);
    end

    always_comb begin
        priority if (fits[0]) begin
            nsh = 2'd0;
        end else if (fits[1]) begin
            nsh = 2'd1;
        end else if (fits[2]) begin
            nsh = 2'd2;
        end else begin
            nsh = 2'd3;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v10_reg <= 1'b0;
        end else if (adv) begin
            v10_reg <= v9_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            t10_reg    <= t9_reg;
            live10_reg <= live9_reg;
            for (int i = 0; i < 3; i++) begin
                p10_reg[i]  <= p9_reg[i];
                vn10_reg[i] <= VN_W'(vc[i] >>> nsh);
            end
        end
    end

    // ---------------- stage 11: squares ----------------
    logic     v11_reg;
    nq_side_t side11_reg;
    logic [59:0] sq11_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v11_reg <= 1'b0;
        end else if (adv) begin
            v11_reg <= v10_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side11_reg.t    <= t10_reg;
            side11_reg.live <= live10_reg;
            for (int i = 0; i < 3; i++) begin
                side11_reg.p[i]  <= p10_reg[i];
                side11_reg.vn[i] <= vn10_reg[i];
                sq11_reg[i]      <= 60'(vn10_reg[i] * vn10_reg[i]);
            end
        end
    end

    // ---------------- stage 12: sum of squares ----------------
    logic     v12_reg;
    nq_side_t side12_reg;
    logic [63:0] sum12_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v12_reg <= 1'b0;
        end else if (adv) begin
            v12_reg <= v11_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side12_reg <= side11_reg;
            sum12_reg  <= 64'(sq11_reg[0]) + 64'(sq11_reg[1]) + 64'(sq11_reg[2]);
        end
    end

    logic [31:0] len_root;
    nq_side_t    side13d;
    logic        v13d;

    rsi_isqrt u_sqrt_len (
        .aclk (aclk),
        .en   (adv),
        .rad  (sum12_reg),
        .root (len_root)
    );

    rsi_delay #(.WIDTH($bits(nq_side_t)), .DEPTH(SQRT_LAT)) u_dly_len (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .vld_in   (v12_reg),
        .data_in  (side12_reg),
        .vld_out  (v13d),
        .data_out (side13d)
    );

    // ---------------- stage 13: normal divide setup ----------------
    logic     v13_reg;
    nd_side_t side13_reg;
    logic signed [VN_W-1:0] vn13_reg [3];
    word_t len13_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v13_reg <= 1'b0;
        end else if (adv) begin
            v13_reg <= v13d;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side13_reg.t        <= side13d.t;
            side13_reg.p        <= side13d.p;
            side13_reg.live     <= side13d.live;
            side13_reg.len_zero <= (len_root == '0);
            len13_reg           <= $signed(len_root);
            for (int i = 0; i < 3; i++) begin
                vn13_reg[i] <= side13d.vn[i];
            end
        end
    end

    word_t    nq [3];
    nd_side_t side14d;
    logic     v14d;

    for (genvar i = 0; i < 3; i++) begin : g_ndiv
        rsi_div u_div_n (
            .aclk (aclk),
            .en   (adv),
            .num  (PROD_W'(vn13_reg[i]) <<< FRAC_BITS),
            .den  (len13_reg),
            .quo  (nq[i])
        );
    end

    rsi_delay #(.WIDTH($bits(nd_side_t)), .DEPTH(DIV_LAT)) u_dly_norm (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .vld_in   (v13_reg),
        .data_in  (side13_reg),
        .vld_out  (v14d),
        .data_out (side14d)
    );

    // ---------------- output register ----------------
    logic [OUT_W-1:0] m_tdata_reg;
    logic             m_hit_reg;
    logic [NORM_W-1:0] nrm [3];

    for (genvar i = 0; i < 3; i++) begin : g_nrm
        // normal is zero when the hit point sits on the center
        assign nrm[i] = side14d.len_zero ? '0 : nq[i][NORM_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= v14d;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_hit_reg <= side14d.live;
            if (side14d.live) begin
                m_tdata_reg <= {2'b00, nrm[2], nrm[1], nrm[0], side14d.p[2], side14d.p[1],
                                side14d.p[0], side14d.t};
            end else begin
                m_tdata_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_hit_reg;
endmodule

// ----- sv/rsi_checker.sv -----
// Port-level checks of the ray/sphere intersection unit and their binding.
`include "assert_macros.svh"

module rsi_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [183:0] m_tdata,
    input logic [0:0]   m_tuser
);
    `ASSERT_IMPLY(a_miss_zero, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata == '0, "miss word has nonzero fields")
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled word changed")
    `ASSERT_ALWAYS(a_ready_follows, aclk, aresetn, s_tready == (!m_tvalid || m_tready), "input ready does not follow output stall")
    `ASSERT_NEXT(a_reset_empty, aclk, 1'b1, !aresetn, !m_tvalid, "output valid after reset")
endmodule

bind ray_sphere_intersect_unit rsi_checker u_rsi_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
